// ===== hdl/esg_pkg.sv =====
`default_nettype none

package esg_pkg;

    // Field widths.
    localparam int POS_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 16;

    // Unity gain in Q1.15; every gain is saturated here.
    localparam logic [GAIN_W-1:0] GAIN_ONE = 16'd32768;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_FRONT  = 3'd0,
        CFG_MIN_BACK   = 3'd1,
        CFG_MAX_FRONT  = 3'd2,
        CFG_MAX_BACK   = 3'd3,
        CFG_INTENSITY  = 3'd4,
        CFG_SPATIALIZE = 3'd5
    } t_cfg_idx;

    // Step counts of the iterative sections of the pipeline.
    localparam int DIST_W   = 25;
    localparam int SQ_STEPS = DIST_W;
    localparam int UD_STEPS = 31;
    localparam int RD_STEPS = 16;
    localparam int TD_STEPS = 17;
    localparam int PW_STEPS = 17;
    localparam int K_W      = 30;

    // 10^-1 in Q2.30.
    localparam logic [63:0] TENTH_Q30 = 64'd107374182;

    typedef logic [PW_STEPS-1:0][K_W-1:0] t_ktab;

    // Floor square root of a 64 bit value, used at elaboration only.
    function automatic logic [31:0] isqrt64(input logic [63:0] n);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        int i;
        rem = n;
        res = '0;
        for (i = 31; i >= 0; i--) begin
            b = 64'd1 << (2 * i);
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
        end
        return res[31:0];
    endfunction

    // Factors 10^(-2^-j) in Q2.30, each the square root of the one before.
    function automatic t_ktab k_table();
        t_ktab k;
        logic [63:0] prev;
        int j;
        k[0] = K_W'(TENTH_Q30);
        for (j = 1; j < PW_STEPS; j++) begin
            prev = {34'd0, k[j-1]} << 30;
            k[j] = K_W'(isqrt64(prev));
        end
        return k;
    endfunction

    localparam t_ktab K_TAB = k_table();

endpackage

`default_nettype wire

// ===== hdl/ellipsoid_sound_gain.sv =====
`default_nettype none

// Ellipsoid sound gain. For each beat of listener position, sound position
// and facing direction (all signed Q8.8) the block returns the attenuated
// gain in Q1.15 and the position for the mixer. It is a fully pipelined
// datapath of 115 register stages: one beat is accepted every cycle unless
// stalled. The depth is set by the bit-serial units in the chain: two 25
// step square roots, six 31 step unit-vector dividers, two 16 step radius
// dividers, a 17 step exponent divider and 17 multiply stages for the power
// of ten. The pipeline advances as a whole; it holds only while a result
// waits at the output and the sink stalls. Configuration registers must be
// written only while the pipeline is empty; the block does not enforce this.
module ellipsoid_sound_gain import esg_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_W-1:0]       i_cfg_data,
    input  wire logic                   i_valid,
    output      logic                   o_stall,
    input  wire logic signed [POS_W-1:0] i_listener_x,
    input  wire logic signed [POS_W-1:0] i_listener_y,
    input  wire logic signed [POS_W-1:0] i_listener_z,
    input  wire logic signed [POS_W-1:0] i_source_x,
    input  wire logic signed [POS_W-1:0] i_source_y,
    input  wire logic signed [POS_W-1:0] i_source_z,
    input  wire logic signed [POS_W-1:0] i_aim_x,
    input  wire logic signed [POS_W-1:0] i_aim_y,
    input  wire logic signed [POS_W-1:0] i_aim_z,
    output      logic                   o_valid,
    input  wire logic                   i_stall,
    output      logic [GAIN_W-1:0]      o_gain,
    output      logic signed [POS_W-1:0] o_emit_x,
    output      logic signed [POS_W-1:0] o_emit_y,
    output      logic signed [POS_W-1:0] o_emit_z
);

    localparam int NSTG = 9 + SQ_STEPS + UD_STEPS + RD_STEPS + TD_STEPS + PW_STEPS;

    // Stage payload types.
    typedef struct packed {
        logic [2:0][16:0] v_mag;
        logic [2:0]       v_neg;
        logic [2:0][15:0] am_mag;
        logic [2:0]       am_neg;
    } t_mag;

    typedef struct packed {
        t_mag        mag;
        logic [33:0] v2;
        logic [31:0] a2;
    } t_sq_in;

    typedef struct packed {
        t_mag        mag;
        logic [49:0] nv;
        logic [49:0] na;
        logic [26:0] remv;
        logic [26:0] rema;
        logic [24:0] rootv;
        logic [24:0] roota;
    } t_sq;

    typedef struct packed {
        logic [26:0] rem;
        logic [24:0] root;
    } t_sqs;

    typedef struct packed {
        logic [5:0][24:0] rem;
        logic [5:0][30:0] q;
        logic [5:0]       neg;
        logic [24:0]      dlen;
        logic [24:0]      la;
    } t_ud;

    typedef struct packed {
        logic [24:0] rem;
        logic [30:0] q;
    } t_uds;

    typedef struct packed {
        logic [2:0][61:0] prod;
        logic [24:0]      dlen;
    } t_dm;

    typedef struct packed {
        logic [31:0] d;
        logic [24:0] dlen;
    } t_ds;

    typedef struct packed {
        logic [1:0][29:0] fb;
        logic [1:0][47:0] fd;
        logic [1:0][15:0] sfb;
        logic [1:0]       flat;
        logic [24:0]      dlen;
    } t_r1;

    typedef struct packed {
        logic [1:0][61:0] n;
        logic [1:0][46:0] den;
        logic [24:0]      dlen;
    } t_r2;

    typedef struct packed {
        logic [1:0][46:0] rem;
        logic [1:0][15:0] nlow;
        logic [1:0][15:0] q;
        logic [1:0][46:0] den;
        logic [24:0]      dlen;
    } t_rd;

    typedef struct packed {
        logic [22:0] x;
        logic [22:0] dv;
        logic        beyond;
        logic        between;
    } t_tp;

    typedef struct packed {
        logic [22:0] rem;
        logic [16:0] nlow;
        logic [22:0] dv;
        logic [16:0] q;
        logic        beyond;
        logic        between;
    } t_td;

    typedef struct packed {
        logic [30:0] p;
        logic [16:0] t;
        logic        beyond;
        logic        between;
    } t_pw;

    typedef struct packed {
        logic [46:0] m;
        logic        beyond;
        logic        between;
    } t_f1;

    // One digit of the square root recurrence.
    function automatic t_sqs sq_step(input logic [26:0] rem, input logic [24:0] root,
                                     input logic [1:0] nb);
        logic [28:0] r2;
        logic [28:0] trial;
        t_sqs o;
        r2    = {rem, nb};
        trial = {2'b00, root, 2'b01};
        if (r2 >= trial) begin
            o.rem  = 27'(r2 - trial);
            o.root = {root[23:0], 1'b1};
        end else begin
            o.rem  = r2[26:0];
            o.root = {root[23:0], 1'b0};
        end
        return o;
    endfunction

    // One bit of a restoring division whose next numerator bits are zero.
    function automatic t_uds ud_step(input logic [24:0] rem, input logic [30:0] q,
                                     input logic [24:0] len);
        logic [25:0] r2;
        t_uds o;
        r2 = {rem, 1'b0};
        if (r2 >= {1'b0, len}) begin
            o.rem = 25'(r2 - {1'b0, len});
            o.q   = {q[29:0], 1'b1};
        end else begin
            o.rem = r2[24:0];
            o.q   = {q[29:0], 1'b0};
        end
        return o;
    endfunction

    // Negative extents count as zero.
    function automatic logic [14:0] ext_clamp(input logic [15:0] v);
        return v[15] ? 15'd0 : v[14:0];
    endfunction

    // Gain saturation at unity.
    function automatic logic [GAIN_W-1:0] gain_sat(input logic [17:0] g);
        return (g > {2'b00, GAIN_ONE}) ? GAIN_ONE : g[GAIN_W-1:0];
    endfunction

    // Configuration registers.
    logic signed [15:0] r_min_front;
    logic signed [15:0] r_min_back;
    logic signed [15:0] r_max_front;
    logic signed [15:0] r_max_back;
    logic [15:0]        r_intensity;
    logic               r_spatialize;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_front  <= 16'sd256;
            r_min_back   <= 16'sd256;
            r_max_front  <= 16'sd2560;
            r_max_back   <= 16'sd2560;
            r_intensity  <= 16'd32768;
            r_spatialize <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MIN_FRONT:  r_min_front  <= i_cfg_data;
                CFG_MIN_BACK:   r_min_back   <= i_cfg_data;
                CFG_MAX_FRONT:  r_max_front  <= i_cfg_data;
                CFG_MAX_BACK:   r_max_back   <= i_cfg_data;
                CFG_INTENSITY:  r_intensity  <= i_cfg_data;
                CFG_SPATIALIZE: r_spatialize <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Clamped ellipse extents: index 0 is the outer ellipse, 1 the inner.
    logic [1:0][14:0] w_f;
    logic [1:0][14:0] w_b;

    always_comb begin
        w_f[0] = ext_clamp(r_max_front);
        w_b[0] = ext_clamp(r_max_back);
        w_f[1] = ext_clamp(r_min_front);
        w_b[1] = ext_clamp(r_min_back);
        if (w_f[1] > w_f[0]) begin
            w_f[1] = w_f[0];
        end
        if (w_b[1] > w_b[0]) begin
            w_b[1] = w_b[0];
        end
    end

    // Pipeline flow: everything moves unless a result is held at the output.
    logic            w_en;
    logic [NSTG-1:0] r_vld;

    assign w_en    = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !w_en;
    assign o_valid = r_vld[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    // Mixer position travels alongside the beat.
    logic [2:0][15:0] r_emit [NSTG];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_emit[0] <= r_spatialize ? {i_source_z, i_source_y, i_source_x}
                                      : {i_listener_z, i_listener_y, i_listener_x};
        end
    end

    for (genvar k = 1; k < NSTG; k++) begin : g_emit
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_emit[k] <= r_emit[k-1];
            end
        end
    end

    // Stage A: offset to the listener, split into sign and magnitude.
    logic signed [15:0] w_lis [3];
    logic signed [15:0] w_src [3];
    logic signed [15:0] w_aim [3];
    logic signed [16:0] w_vd  [3];
    t_mag               n_a;
    t_mag               r_a;

    assign w_lis[0] = i_listener_x;
    assign w_lis[1] = i_listener_y;
    assign w_lis[2] = i_listener_z;
    assign w_src[0] = i_source_x;
    assign w_src[1] = i_source_y;
    assign w_src[2] = i_source_z;
    assign w_aim[0] = i_aim_x;
    assign w_aim[1] = i_aim_y;
    assign w_aim[2] = i_aim_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_vd[i]        = {w_lis[i][15], w_lis[i]} - {w_src[i][15], w_src[i]};
            n_a.v_neg[i]   = w_vd[i][16];
            n_a.v_mag[i]   = w_vd[i][16] ? 17'(-w_vd[i]) : w_vd[i];
            n_a.am_neg[i]  = w_aim[i][15];
            n_a.am_mag[i]  = w_aim[i][15] ? 16'(-w_aim[i]) : w_aim[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a <= n_a;
        end
    end

    // Stage B: squared lengths of both vectors.
    t_sq_in r_b;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_b.mag <= r_a;
            r_b.v2  <= ({17'd0, r_a.v_mag[0]} * {17'd0, r_a.v_mag[0]})
                     + ({17'd0, r_a.v_mag[1]} * {17'd0, r_a.v_mag[1]})
                     + ({17'd0, r_a.v_mag[2]} * {17'd0, r_a.v_mag[2]});
            r_b.a2  <= ({16'd0, r_a.am_mag[0]} * {16'd0, r_a.am_mag[0]})
                     + ({16'd0, r_a.am_mag[1]} * {16'd0, r_a.am_mag[1]})
                     + ({16'd0, r_a.am_mag[2]} * {16'd0, r_a.am_mag[2]});
        end
    end

    // Square roots: distance and aim length in Q8.16, one bit per stage.
    t_sq r_sq [SQ_STEPS];

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        t_sq  w_in;
        t_sqs w_sv;
        t_sqs w_sa;
        if (k == 0) begin : g_first
            always_comb begin
                w_in       = '0;
                w_in.mag   = r_b.mag;
                w_in.nv    = {r_b.v2, 16'd0};
                w_in.na    = {2'b00, r_b.a2, 16'd0};
            end
        end else begin : g_next
            assign w_in = r_sq[k-1];
        end
        assign w_sv = sq_step(w_in.remv, w_in.rootv, w_in.nv[49:48]);
        assign w_sa = sq_step(w_in.rema, w_in.roota, w_in.na[49:48]);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[k].mag   <= w_in.mag;
                r_sq[k].nv    <= {w_in.nv[47:0], 2'b00};
                r_sq[k].na    <= {w_in.na[47:0], 2'b00};
                r_sq[k].remv  <= w_sv.rem;
                r_sq[k].rootv <= w_sv.root;
                r_sq[k].rema  <= w_sa.rem;
                r_sq[k].roota <= w_sa.root;
            end
        end
    end

    // Unit vectors in Q2.30: lanes 0..2 the aim, lanes 3..5 the offset.
    t_ud r_ud [UD_STEPS];

    for (genvar k = 0; k < UD_STEPS; k++) begin : g_ud
        t_ud  w_in;
        t_uds w_st [6];
        if (k == 0) begin : g_first
            always_comb begin
                w_in      = '0;
                w_in.dlen = r_sq[SQ_STEPS-1].rootv;
                w_in.la   = r_sq[SQ_STEPS-1].roota;
                for (int i = 0; i < 3; i++) begin
                    w_in.rem[i]   = {2'b00, r_sq[SQ_STEPS-1].mag.am_mag[i], 7'd0};
                    w_in.neg[i]   = r_sq[SQ_STEPS-1].mag.am_neg[i];
                    w_in.rem[i+3] = {1'b0, r_sq[SQ_STEPS-1].mag.v_mag[i], 7'd0};
                    w_in.neg[i+3] = r_sq[SQ_STEPS-1].mag.v_neg[i];
                end
            end
        end else begin : g_next
            assign w_in = r_ud[k-1];
        end
        for (genvar i = 0; i < 3; i++) begin : g_lane
            assign w_st[i]   = ud_step(w_in.rem[i], w_in.q[i], w_in.la);
            assign w_st[i+3] = ud_step(w_in.rem[i+3], w_in.q[i+3], w_in.dlen);
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_ud[k].dlen <= w_in.dlen;
                r_ud[k].la   <= w_in.la;
                r_ud[k].neg  <= w_in.neg;
                for (int i = 0; i < 6; i++) begin
                    r_ud[k].rem[i] <= w_st[i].rem;
                    r_ud[k].q[i]   <= w_st[i].q;
                end
            end
        end
    end

    // Dot product terms; a zero length gives a zero unit vector.
    logic signed [31:0] w_u [3];
    logic signed [31:0] w_w [3];
    t_dm                r_dm;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_ud[UD_STEPS-1].la == '0) begin
                w_u[i] = '0;
            end else if (r_ud[UD_STEPS-1].neg[i]) begin
                w_u[i] = -$signed({1'b0, r_ud[UD_STEPS-1].q[i]});
            end else begin
                w_u[i] = $signed({1'b0, r_ud[UD_STEPS-1].q[i]});
            end
            if (r_ud[UD_STEPS-1].dlen == '0) begin
                w_w[i] = '0;
            end else if (r_ud[UD_STEPS-1].neg[i+3]) begin
                w_w[i] = -$signed({1'b0, r_ud[UD_STEPS-1].q[i+3]});
            end else begin
                w_w[i] = $signed({1'b0, r_ud[UD_STEPS-1].q[i+3]});
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dm.dlen <= r_ud[UD_STEPS-1].dlen;
            for (int i = 0; i < 3; i++) begin
                r_dm.prod[i] <= 62'(64'(w_u[i]) * 64'(w_w[i]));
            end
        end
    end

    // Cosine: sum, divide by 2^30 toward zero, clamp to plus or minus one.
    logic signed [63:0] w_sum;
    logic signed [63:0] w_cq;
    logic signed [31:0] n_d;
    t_ds                r_ds;

    always_comb begin
        w_sum = 64'($signed(r_dm.prod[0])) + 64'($signed(r_dm.prod[1]))
              + 64'($signed(r_dm.prod[2]));
        if (w_sum < 0) begin
            w_cq = (w_sum + 64'sd1073741823) >>> 30;
        end else begin
            w_cq = w_sum >>> 30;
        end
        if (w_cq > 64'sd1073741824) begin
            n_d = 32'sd1073741824;
        end else if (w_cq < -64'sd1073741824) begin
            n_d = -32'sd1073741824;
        end else begin
            n_d = 32'(w_cq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ds.d    <= n_d;
            r_ds.dlen <= r_dm.dlen;
        end
    end

    // Radius terms for both ellipses.
    logic signed [15:0] w_fmb [2];
    t_r1                r_r1;

    always_comb begin
        for (int e = 0; e < 2; e++) begin
            w_fmb[e] = $signed({1'b0, w_f[e]}) - $signed({1'b0, w_b[e]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1.dlen <= r_ds.dlen;
            for (int e = 0; e < 2; e++) begin
                r_r1.fb[e]   <= {15'd0, w_f[e]} * {15'd0, w_b[e]};
                r_r1.fd[e]   <= 48'(w_fmb[e]) * 48'($signed(r_ds.d));
                r_r1.sfb[e]  <= {1'b0, w_f[e]} + {1'b0, w_b[e]};
                r_r1.flat[e] <= (w_f[e] == '0) || (w_b[e] == '0);
            end
        end
    end

    // Divider operands, with half the divisor added for rounding.
    logic signed [47:0] w_den [2];
    logic               w_bad [2];
    t_r2                n_r2;
    t_r2                r_r2;

    always_comb begin
        n_r2.dlen = r_r1.dlen;
        for (int e = 0; e < 2; e++) begin
            w_den[e] = $signed({2'b00, r_r1.sfb[e], 30'd0}) - $signed(r_r1.fd[e]);
            w_bad[e] = r_r1.flat[e] || (w_den[e] <= 0);
            if (w_bad[e]) begin
                n_r2.den[e] = 47'd1;
                n_r2.n[e]   = '0;
            end else begin
                n_r2.den[e] = w_den[e][46:0];
                n_r2.n[e]   = {1'b0, r_r1.fb[e], 31'd0} + {16'd0, w_den[e][46:1]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r2 <= n_r2;
        end
    end

    // Radius division, one quotient bit per stage.
    t_rd r_rd [RD_STEPS];

    for (genvar k = 0; k < RD_STEPS; k++) begin : g_rd
        t_rd         w_in;
        logic [47:0] w_r2 [2];
        if (k == 0) begin : g_first
            always_comb begin
                w_in      = '0;
                w_in.dlen = r_r2.dlen;
                for (int e = 0; e < 2; e++) begin
                    w_in.rem[e]  = {1'b0, r_r2.n[e][61:16]};
                    w_in.nlow[e] = r_r2.n[e][15:0];
                    w_in.den[e]  = r_r2.den[e];
                end
            end
        end else begin : g_next
            assign w_in = r_rd[k-1];
        end
        always_comb begin
            for (int e = 0; e < 2; e++) begin
                w_r2[e] = {w_in.rem[e], w_in.nlow[e][15]};
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rd[k].dlen <= w_in.dlen;
                for (int e = 0; e < 2; e++) begin
                    r_rd[k].den[e]  <= w_in.den[e];
                    r_rd[k].nlow[e] <= {w_in.nlow[e][14:0], 1'b0};
                    if (w_r2[e] >= {1'b0, w_in.den[e]}) begin
                        r_rd[k].rem[e] <= 47'(w_r2[e] - {1'b0, w_in.den[e]});
                        r_rd[k].q[e]   <= {w_in.q[e][14:0], 1'b1};
                    end else begin
                        r_rd[k].rem[e] <= w_r2[e][46:0];
                        r_rd[k].q[e]   <= {w_in.q[e][14:0], 1'b0};
                    end
                end
            end
        end
    end

    // Region of the listener and operands of the exponent.
    logic [15:0] w_maxr;
    logic [15:0] w_minr;
    logic [24:0] w_mxs;
    logic [24:0] w_mns;
    t_tp         n_tp;
    t_tp         r_tp;

    always_comb begin
        w_maxr         = r_rd[RD_STEPS-1].q[0];
        w_minr         = r_rd[RD_STEPS-1].q[1];
        w_mxs          = {1'b0, w_maxr, 8'd0};
        w_mns          = {1'b0, w_minr, 8'd0};
        n_tp.beyond    = r_rd[RD_STEPS-1].dlen > w_mxs;
        n_tp.between   = !n_tp.beyond && (r_rd[RD_STEPS-1].dlen > w_mns)
                       && (w_maxr > w_minr);
        if (n_tp.between) begin
            n_tp.x  = 23'(r_rd[RD_STEPS-1].dlen - w_mns);
            n_tp.dv = 23'({w_maxr - w_minr, 8'd0});
        end else begin
            n_tp.x  = '0;
            n_tp.dv = 23'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tp <= n_tp;
        end
    end

    // Exponent division in Q1.16.
    t_td r_td [TD_STEPS];

    for (genvar k = 0; k < TD_STEPS; k++) begin : g_td
        t_td         w_in;
        logic [23:0] w_r2;
        if (k == 0) begin : g_first
            always_comb begin
                w_in         = '0;
                w_in.rem     = {1'b0, r_tp.x[22:1]};
                w_in.nlow    = {r_tp.x[0], 16'd0};
                w_in.dv      = r_tp.dv;
                w_in.beyond  = r_tp.beyond;
                w_in.between = r_tp.between;
            end
        end else begin : g_next
            assign w_in = r_td[k-1];
        end
        assign w_r2 = {w_in.rem, w_in.nlow[16]};
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_td[k].dv      <= w_in.dv;
                r_td[k].beyond  <= w_in.beyond;
                r_td[k].between <= w_in.between;
                r_td[k].nlow    <= {w_in.nlow[15:0], 1'b0};
                if (w_r2 >= {1'b0, w_in.dv}) begin
                    r_td[k].rem <= 23'(w_r2 - {1'b0, w_in.dv});
                    r_td[k].q   <= {w_in.q[15:0], 1'b1};
                end else begin
                    r_td[k].rem <= w_r2[22:0];
                    r_td[k].q   <= {w_in.q[15:0], 1'b0};
                end
            end
        end
    end

    // Power of ten: one rounded factor per stage, whole unit first.
    t_pw r_pw [PW_STEPS];

    for (genvar k = 0; k < PW_STEPS; k++) begin : g_pw
        t_pw         w_in;
        logic [61:0] w_prod;
        if (k == 0) begin : g_first
            always_comb begin
                w_in         = '0;
                w_in.p       = 31'd1 << 30;
                w_in.t       = r_td[TD_STEPS-1].q;
                w_in.beyond  = r_td[TD_STEPS-1].beyond;
                w_in.between = r_td[TD_STEPS-1].between;
            end
        end else begin : g_next
            assign w_in = r_pw[k-1];
        end
        assign w_prod = ({31'd0, w_in.p} * {32'd0, K_TAB[k]}) + (62'd1 << 29);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pw[k].t       <= w_in.t;
                r_pw[k].beyond  <= w_in.beyond;
                r_pw[k].between <= w_in.between;
                r_pw[k].p       <= w_in.t[PW_STEPS-1-k] ? w_prod[60:30] : w_in.p;
            end
        end
    end

    // Scale the intensity.
    t_f1 r_f1;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f1.m       <= {31'd0, r_intensity} * {16'd0, r_pw[PW_STEPS-1].p};
            r_f1.beyond  <= r_pw[PW_STEPS-1].beyond;
            r_f1.between <= r_pw[PW_STEPS-1].between;
        end
    end

    // Round, pick the region and saturate into the output register.
    logic [46:0]       w_rnd;
    logic [GAIN_W-1:0] n_gain;
    logic [GAIN_W-1:0] r_gain;

    always_comb begin
        w_rnd = (r_f1.m + (47'd1 << 29)) >> 30;
        if (r_f1.beyond) begin
            n_gain = '0;
        end else if (r_f1.between) begin
            n_gain = gain_sat(w_rnd[17:0]);
        end else begin
            n_gain = gain_sat({2'b00, r_intensity});
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gain <= n_gain;
        end
    end

    assign o_gain   = r_gain;
    assign o_emit_x = r_emit[NSTG-1][0];
    assign o_emit_y = r_emit[NSTG-1][1];
    assign o_emit_z = r_emit[NSTG-1][2];

endmodule

`default_nettype wire

// ===== hdl/esg_chk.sv =====
`default_nettype none

module esg_chk import esg_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_stall,
    input wire logic              o_valid,
    input wire logic              o_stall,
    input wire logic [GAIN_W-1:0] o_gain
);

    // The gain never exceeds unity.
    a_gain_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_gain <= GAIN_ONE))
        else $error("gain above unity");

    // The pipeline only holds back a beat while its result is held.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled without a held result");

    // A held result keeps its gain.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_gain)))
        else $error("held result changed");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind ellipsoid_sound_gain esg_chk u_esg_chk (.*);

`default_nettype wire
